/* rtl/cwi_pkg.sv */
// ----------------------------------------------------------------------------
// cwi_pkg
// Shared types and constants of the cyclic waypoint interpolator.
// ----------------------------------------------------------------------------
package cwi_pkg;

   localparam int DEFAULT_MAX_WAYPOINTS = 16;
   localparam int COORD_W = 32;
   localparam int TIME_W  = 16;
   localparam int SPEED_W = 16;
   localparam int FRAC_W  = 24;
   localparam int SEG_W   = $clog2(DEFAULT_MAX_WAYPOINTS);
   localparam int PCNT_W  = $clog2(DEFAULT_MAX_WAYPOINTS + 1);
   localparam int UNIT_W  = 68;   // wide enough for the sum of three squares
   localparam int STEP_W  = 6;
   localparam int NUM_W   = 40;   // speed * time << 8
   localparam int DIFF_W  = 33;   // magnitude of a coordinate difference

   localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd384;
   localparam logic [UNIT_W-1:0]  SHORT_LEN   = 68'd6;
   localparam logic [NUM_W-1:0]   ONE_Q16     = 40'd65536;
   localparam logic [FRAC_W-1:0]  INC_MAX     = 24'hFF_FFFF;

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]                cmd;
      logic [TIME_W-1:0]         elapsed_time;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic signed [COORD_W-1:0] base_x;
      logic signed [COORD_W-1:0] base_y;
      logic signed [COORD_W-1:0] base_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [SEG_W-1:0]          segment_index;
      logic [PCNT_W-1:0]         point_count;
      logic                      add_dropped;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } waypoint_type;

endpackage

/* rtl/cwi_addsub.sv */
// ----------------------------------------------------------------------------
// cwi_addsub
// Shared wide adder / subtractor with borrow out.
// ----------------------------------------------------------------------------
module cwi_addsub (
   input  logic [cwi_pkg::UNIT_W-1:0] op_a,
   input  logic [cwi_pkg::UNIT_W-1:0] op_b,
   input  logic                       sub,
   output logic [cwi_pkg::UNIT_W-1:0] result,
   output logic                       borrow
);
   logic [cwi_pkg::UNIT_W-1:0] b_in;
   logic                       carry;

   assign b_in = sub ? ~op_b : op_b;
   assign {carry, result} = {1'b0, op_a} + {1'b0, b_in} + {{cwi_pkg::UNIT_W{1'b0}}, sub};
   // a - b borrows when a < b
   assign borrow = sub & ~carry;
endmodule

/* rtl/cwi_wp_ram.sv */
// ----------------------------------------------------------------------------
// cwi_wp_ram
// Waypoint store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cwi_wp_ram #(
   parameter int DEPTH = cwi_pkg::DEFAULT_MAX_WAYPOINTS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  cwi_pkg::waypoint_type wr_data,
   input  logic [AW-1:0]         rd_addr,
   output cwi_pkg::waypoint_type rd_data
);
   cwi_pkg::waypoint_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/cyclic_waypoint_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// cyclic_waypoint_interpolator_unit
// Piecewise linear path interpolation over a cyclic waypoint table.
// ----------------------------------------------------------------------------
// Add, clear and unused commands and ticks with fewer than two waypoints: result
// beat in the cycle after the request beat. A tick on a path runs on the shared
// 68-bit adder: table reads, three 33-step squares (a negative difference takes an
// extra negation state), 34-step root, 16-step product, 40-step divide (skipped on a
// short segment), 9-step modulo and three blends (difference, 16-step product, add).
// One item at a time; ready only while idle. Synchronous active-high reset clears
// count, segment, fraction and position and sets the speed to 1.5; the table is not cleared.
module cyclic_waypoint_interpolator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cwi_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cwi_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [cwi_pkg::SPEED_W-1:0]   csr_wr_data
);
   localparam int MAX_WAYPOINTS = cwi_pkg::DEFAULT_MAX_WAYPOINTS;
   localparam int IDX_W  = $clog2(MAX_WAYPOINTS);
   localparam int CNT_W  = $clog2(MAX_WAYPOINTS + 1);
   localparam int V_W    = $clog2(MAX_WAYPOINTS + 257);
   localparam int UW     = cwi_pkg::UNIT_W;
   localparam int SW     = cwi_pkg::STEP_W;
   localparam int NW     = cwi_pkg::NUM_W;
   localparam int SEG_W  = cwi_pkg::SEG_W;
   localparam int PCNT_W = cwi_pkg::PCNT_W;
   localparam int FW     = cwi_pkg::FRAC_W;

   typedef enum logic [4:0] {
      S_IDLE, S_ADDR, S_RDA, S_RDB, S_DIFF, S_NEG, S_SQMUL, S_SQRT, S_SPMUL,
      S_DIVSET, S_DIV, S_FRAC, S_SEGADD, S_MOD, S_BDIFF, S_BMUL, S_BADD, S_RESP
   } state_type;

   state_type               state_ff;
   logic                    blend_ff;
   logic [1:0]              axis_ff;
   logic [SW-1:0]           step_ff;
   logic [UW-1:0]           acc_ff, mcand_ff, root_ff;
   logic [NW-1:0]           mplier_ff;
   cwi_pkg::waypoint_type   a_ff, b_ff;
   cwi_pkg::req_type        req_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [IDX_W-1:0]        cur_ff;
   logic [FW-1:0]           frac_ff;
   logic signed [31:0]      last_ff [3];
   logic                    dropped_ff;
   logic [cwi_pkg::SPEED_W-1:0] speed_ff;

   logic                    accept;
   logic [IDX_W:0]          cur_inc;
   logic [IDX_W-1:0]        nxt, rd_addr;
   logic                    wr_en;
   cwi_pkg::waypoint_type   rd_data, wr_data;
   logic [UW-1:0]           ua, ub, usum, div_t;
   logic                    usub, uborrow;
   logic signed [31:0]      a_ax, b_ax;
   logic [FW-1:0]           inc;
   logic                    last_step;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign last_step = (step_ff == SW'(1));

   assign cur_inc = {1'b0, cur_ff} + 1'b1;
   assign nxt     = (CNT_W'(cur_inc) == count_ff) ? '0 : cur_inc[IDX_W-1:0];
   assign rd_addr = (state_ff == S_RDA) ? nxt : cur_ff;

   assign wr_en   = accept && (req_data.cmd == cwi_pkg::CMD_ADD) &&
                    (count_ff != CNT_W'(MAX_WAYPOINTS));
   assign wr_data = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};

   cwi_wp_ram #(.DEPTH(MAX_WAYPOINTS), .AW(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (axis_ff)
         2'd0:    begin a_ax = a_ff.x; b_ax = b_ff.x; end
         2'd1:    begin a_ax = a_ff.y; b_ax = b_ff.y; end
         default: begin a_ax = a_ff.z; b_ax = b_ff.z; end
      endcase
   end

   assign inc   = (mplier_ff[NW-1:FW] != '0) ? cwi_pkg::INC_MAX : mplier_ff[FW-1:0];
   assign div_t = {acc_ff[UW-2:0], mplier_ff[NW-1]};

   always_comb begin
      ua   = acc_ff;
      ub   = mcand_ff;
      usub = 1'b0;
      unique case (state_ff)
         S_DIFF, S_BDIFF: begin
            ua = {{(UW-32){b_ax[31]}}, b_ax};
            ub = {{(UW-32){a_ax[31]}}, a_ax};
            usub = 1'b1;
         end
         S_NEG: begin
            ua = {{(UW-32){a_ax[31]}}, a_ax};
            ub = {{(UW-32){b_ax[31]}}, b_ax};
            usub = 1'b1;
         end
         S_SQRT: begin
            ub = root_ff | mcand_ff;
            usub = 1'b1;
         end
         S_DIV: begin
            ua = div_t;
            ub = root_ff;
            usub = 1'b1;
         end
         S_MOD: begin
            ua = div_t;
            ub = UW'(count_ff);
            usub = 1'b1;
         end
         S_FRAC: begin
            ua = UW'(frac_ff);
            ub = UW'(inc);
         end
         S_SEGADD: begin
            ua = UW'(cur_ff);
            ub = UW'(acc_ff[24:16]);
         end
         S_BADD: begin
            ua = {{(UW-32){a_ax[31]}}, a_ax};
            ub = acc_ff >> 16;
         end
         default: begin
         end
      endcase
   end

   cwi_addsub u_unit (
      .op_a   (ua),
      .op_b   (ub),
      .sub    (usub),
      .result (usum),
      .borrow (uborrow)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         cur_ff     <= '0;
         frac_ff    <= '0;
         last_ff    <= '{32'sd0, 32'sd0, 32'sd0};
         dropped_ff <= 1'b0;
         speed_ff   <= cwi_pkg::SPEED_RESET;
         blend_ff   <= 1'b0;
         axis_ff    <= '0;
         step_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            speed_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff     <= req_data;
                  blend_ff   <= 1'b0;
                  dropped_ff <= (req_data.cmd == cwi_pkg::CMD_ADD) &&
                                (count_ff == CNT_W'(MAX_WAYPOINTS));
                  state_ff   <= ((req_data.cmd == cwi_pkg::CMD_TICK) &&
                                 (count_ff >= CNT_W'(2))) ? S_ADDR : S_RESP;
                  unique case (req_data.cmd)
                     cwi_pkg::CMD_TICK: begin
                        if (count_ff < CNT_W'(2)) begin
                           last_ff <= '{req_data.base_x, req_data.base_y, req_data.base_z};
                        end
                     end
                     cwi_pkg::CMD_ADD: begin
                        if (count_ff != CNT_W'(MAX_WAYPOINTS)) begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     cwi_pkg::CMD_CLEAR: begin
                        count_ff <= '0;
                        cur_ff   <= '0;
                        frac_ff  <= '0;
                        last_ff  <= '{req_data.base_x, req_data.base_y, req_data.base_z};
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_ADDR: state_ff <= S_RDA;
            S_RDA: begin
               a_ff     <= rd_data;
               state_ff <= S_RDB;
            end
            S_RDB: begin
               b_ff     <= rd_data;
               axis_ff  <= '0;
               acc_ff   <= '0;
               state_ff <= blend_ff ? S_BDIFF : S_DIFF;
            end
            S_DIFF, S_NEG: begin
               // keep the magnitude of the difference
               if (state_ff == S_DIFF && usum[UW-1]) begin
                  state_ff <= S_NEG;
               end else begin
                  mcand_ff  <= usum;
                  mplier_ff <= NW'(usum[cwi_pkg::DIFF_W-1:0]);
                  step_ff   <= SW'(cwi_pkg::DIFF_W);
                  state_ff  <= S_SQMUL;
               end
            end
            S_SQMUL, S_SPMUL, S_BMUL: begin
               if (mplier_ff[0]) begin
                  acc_ff <= usum;
               end
               mplier_ff <= mplier_ff >> 1;
               if (last_step && state_ff == S_SQMUL && axis_ff == 2'd2) begin
                  root_ff  <= '0;
                  mcand_ff <= UW'(1) << (UW - 2);
                  step_ff  <= SW'(UW / 2);
                  state_ff <= S_SQRT;
               end else begin
                  mcand_ff <= mcand_ff << 1;
                  step_ff  <= step_ff - 1'b1;
                  if (last_step) begin
                     if (state_ff == S_SPMUL) begin
                        state_ff <= S_DIVSET;
                     end else if (state_ff == S_BMUL) begin
                        state_ff <= S_BADD;
                     end else begin
                        axis_ff  <= axis_ff + 1'b1;
                        state_ff <= S_DIFF;
                     end
                  end
               end
            end
            S_SQRT: begin
               if (!uborrow) begin
                  root_ff <= (root_ff >> 1) | mcand_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               if (last_step) begin
                  acc_ff    <= '0;
                  mcand_ff  <= UW'(speed_ff);
                  mplier_ff <= NW'(req_ff.elapsed_time);
                  step_ff   <= SW'(cwi_pkg::TIME_W);
                  state_ff  <= S_SPMUL;
               end else begin
                  if (!uborrow) begin
                     acc_ff <= usum;
                  end
                  mcand_ff <= mcand_ff >> 2;
                  step_ff  <= step_ff - 1'b1;
               end
            end
            S_DIVSET: begin
               if (root_ff <= cwi_pkg::SHORT_LEN) begin
                  mplier_ff <= cwi_pkg::ONE_Q16;
                  state_ff  <= S_FRAC;
               end else begin
                  mplier_ff <= {acc_ff[NW-9:0], 8'd0};
                  acc_ff    <= '0;
                  step_ff   <= SW'(NW);
                  state_ff  <= S_DIV;
               end
            end
            S_DIV: begin
               acc_ff    <= uborrow ? div_t : usum;
               mplier_ff <= {mplier_ff[NW-2:0], ~uborrow};
               step_ff   <= step_ff - 1'b1;
               if (last_step) begin
                  state_ff <= S_FRAC;
               end
            end
            S_FRAC: begin
               acc_ff   <= usum;
               frac_ff  <= FW'(usum[15:0]);
               state_ff <= S_SEGADD;
            end
            S_SEGADD: begin
               // left-align the index sum for the bitwise modulo
               mplier_ff <= NW'(usum[V_W-1:0]) << (NW - V_W);
               acc_ff    <= '0;
               step_ff   <= SW'(V_W);
               state_ff  <= S_MOD;
            end
            S_MOD: begin
               acc_ff    <= uborrow ? div_t : usum;
               mplier_ff <= mplier_ff << 1;
               step_ff   <= step_ff - 1'b1;
               if (last_step) begin
                  cur_ff   <= uborrow ? div_t[IDX_W-1:0] : usum[IDX_W-1:0];
                  blend_ff <= 1'b1;
                  state_ff <= S_ADDR;
               end
            end
            S_BDIFF: begin
               mcand_ff  <= usum;
               acc_ff    <= '0;
               mplier_ff <= NW'(frac_ff[15:0]);
               step_ff   <= SW'(16);
               state_ff  <= S_BMUL;
            end
            S_BADD: begin
               last_ff[axis_ff] <= usum[31:0];
               if (axis_ff == 2'd2) begin
                  state_ff <= S_RESP;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= S_BDIFF;
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_data.pos_x         = last_ff[0];
   assign rsp_data.pos_y         = last_ff[1];
   assign rsp_data.pos_z         = last_ff[2];
   assign rsp_data.segment_index = SEG_W'(cur_ff);
   assign rsp_data.point_count   = PCNT_W'(count_ff);
   assign rsp_data.add_dropped   = dropped_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while a result beat is held");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_WAYPOINTS)) else $error("waypoint count overflow");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) || (CNT_W'(cur_ff) < count_ff)) else $error("segment out of range");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      $rose(dropped_ff) |-> (count_ff == CNT_W'(MAX_WAYPOINTS)))
      else $error("add dropped with room left");
endmodule
